[design/iatc_pkg.sv]
// ----------------------------------------------------------------------------
// iatc_pkg
// Shared types and constants of the address text classifier: character
// classes, result codes, the token passed from front to back, and limits.
// ----------------------------------------------------------------------------
`default_nettype none

package iatc_pkg;

  // character class decided by the front end
  typedef enum logic [2:0] {
    CC_OTHER     = 3'd0,
    CC_DEC       = 3'd1,
    CC_HEX_ALPHA = 3'd2,
    CC_DOT       = 3'd3,
    CC_COLON     = 3'd4
  } char_cls_e;

  // result codes
  typedef enum logic [1:0] {
    AC_NONE = 2'd0,
    AC_V4   = 2'd1,
    AC_V6   = 2'd2
  } addr_class_e;

  // one classified character on its way to the back end
  typedef struct packed {
    char_cls_e  cls;
    logic [3:0] digit;
    logic       has_char;
    logic       last;
  } token_t;

  // character codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;

  // dotted decimal limits
  localparam logic [8:0] V4_MAX      = 9'd255;
  localparam logic [8:0] V4_SAT      = 9'd256;
  localparam logic [2:0] V4_DOTS     = 3'd3;
  localparam logic [2:0] V4_DOT_SAT  = 3'd4;
  localparam logic [2:0] V4_LEN_SAT  = 3'd7;

  // colon hex limits
  localparam logic [3:0] V6_COLONS    = 4'd7;
  localparam logic [3:0] V6_COLON_SAT = 4'd8;
  localparam logic [2:0] V6_LEN_MAX   = 3'd4;
  localparam logic [2:0] V6_LEN_SAT   = 3'd5;

endpackage

`default_nettype wire

[design/iatc_in_if.sv]
// ----------------------------------------------------------------------------
// iatc_in_if
// Character channel: one byte of the address string per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface iatc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       last;

  modport source (output valid, output char_code, output has_char, output last,
                  input ready);
  modport sink   (input valid, input char_code, input has_char, input last,
                  output ready);
endinterface

`default_nettype wire

[design/iatc_out_if.sv]
// ----------------------------------------------------------------------------
// iatc_out_if
// Result channel: one address class per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface iatc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] address_class;

  modport source (output valid, output address_class, input ready);
  modport sink   (input valid, input address_class, output ready);
endinterface

`default_nettype wire

[design/ip_address_text_classifier.sv]
// ----------------------------------------------------------------------------
// ip_address_text_classifier
// Classifies an address string as dotted decimal IPv4, colon hex IPv6 or
// neither, one character per transfer.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : one byte of the string per transfer; last marks the final byte.
//           has_char low with last high closes the string as it stands (an
//           empty string gives neither); has_char and last both low is
//           dropped.
//   res_o : one address_class per string, 0 neither, 1 IPv4, 2 IPv6.
//   Throughput: one character per cycle, sustained, strings back to back, while in_i.ready stays high.
//   Path:   the class of a string shows on res_o once the last byte's token
//           has passed the token queue and then the result register.
//   Stalls: while a result waits on res_o, characters of the next string
//           keep flowing through the back end; only the next last token
//           waits, and once the FifoDepth queue fills in_i.ready drops.
//   Reset: queue empty, no result pending, all check state at its start
//          values; in_i.ready is high from the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_address_text_classifier #(
  parameter int FifoDepth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iatc_in_if.sink    in_i,
  iatc_out_if.source res_o
);
  import iatc_pkg::*;

  token_t wr_tok, rd_tok;
  logic   wr, full, rd, tok_valid;

  // classify and push
  iatc_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .tok_o  (wr_tok),
    .wr_o   (wr)
  );

  // decoupling queue
  iatc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_data_i (wr_tok),
    .full_o    (full),
    .rd_i      (rd),
    .rd_data_o (rd_tok),
    .valid_o   (tok_valid)
  );

  // checks and result
  iatc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (rd_tok),
    .tok_valid_i (tok_valid),
    .pop_o       (rd),
    .res_o       (res_o)
  );

  // a pushed token is visible to the back end on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> tok_valid)
    else $error("queued token not visible");

  // a popped last token always leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd && rd_tok.last) |=> res_o.valid)
    else $error("last token produced no result");

  // never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd |-> tok_valid)
    else $error("pop from empty queue");

  // a new result only follows a popped last token
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(rd && rd_tok.last))
    else $error("result without last token");

endmodule

`default_nettype wire

[design/iatc_front.sv]
// ----------------------------------------------------------------------------
// iatc_front
// Accepts characters and classifies them into tokens for the queue. Items
// with no character and no last flag carry nothing and are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module iatc_front (
  iatc_in_if.sink          in_i,
  input  wire logic        full_i,
  output iatc_pkg::token_t tok_o,
  output logic             wr_o
);
  import iatc_pkg::*;

  logic is_dec, is_alpha;

  // accept whenever the queue has room
  assign in_i.ready = !full_i;
  assign wr_o       = in_i.valid && !full_i && (in_i.has_char || in_i.last);

  // character classification
  assign is_dec   = (in_i.char_code >= CH_ZERO) && (in_i.char_code <= CH_NINE);
  assign is_alpha = ((in_i.char_code >= CH_LA) && (in_i.char_code <= CH_LF)) ||
                    ((in_i.char_code >= CH_UA) && (in_i.char_code <= CH_UF));

  always_comb begin
    tok_o.has_char = in_i.has_char;
    tok_o.last     = in_i.last;
    // decimal digit value is the low nibble of its code
    tok_o.digit    = in_i.char_code[3:0];
    priority if (in_i.char_code == CH_DOT) begin
      tok_o.cls = CC_DOT;
    end else if (in_i.char_code == CH_COLON) begin
      tok_o.cls = CC_COLON;
    end else if (is_dec) begin
      tok_o.cls = CC_DEC;
    end else if (is_alpha) begin
      tok_o.cls = CC_HEX_ALPHA;
    end else begin
      tok_o.cls = CC_OTHER;
    end
  end

endmodule

`default_nettype wire

[design/iatc_fifo.sv]
// ----------------------------------------------------------------------------
// iatc_fifo
// Short token queue between front and back; first word shows on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module iatc_fifo #(
  parameter int Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire iatc_pkg::token_t wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_i,
  output iatc_pkg::token_t      rd_data_o,
  output logic                  valid_o
);
  import iatc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  token_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o    = (count_q == FullCnt);
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

[design/iatc_back.sv]
// ----------------------------------------------------------------------------
// iatc_back
// Runs the dotted decimal and colon hex checks on each token and registers
// the class when the last token of a string goes through.
// ----------------------------------------------------------------------------
`default_nettype none

module iatc_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire iatc_pkg::token_t tok_i,
  input  wire logic             tok_valid_i,
  output logic                  pop_o,
  iatc_out_if.source            res_o
);
  import iatc_pkg::*;

  logic        v4_ok_q, v4_ok_d;
  logic [2:0]  v4_dot_cnt_q, v4_dot_cnt_d;
  logic [2:0]  v4_len_q, v4_len_d;
  logic [8:0]  v4_val_q, v4_val_d;
  logic        v4_lz_q, v4_lz_d;
  logic        v6_ok_q, v6_ok_d;
  logic [3:0]  v6_colon_cnt_q, v6_colon_cnt_d;
  logic [2:0]  v6_len_q, v6_len_d;
  logic [12:0] v4_mul;
  logic        is_v4, is_v6, last_pop;
  logic        res_valid_q, res_valid_d;
  addr_class_e res_class_q, res_class_d;

  // take a token unless it is a last token while a finished result still waits untaken
  assign pop_o    = tok_valid_i && (!tok_i.last || !res_valid_q || res_o.ready);
  assign last_pop = pop_o && tok_i.last;

  // field value times ten plus digit
  assign v4_mul = {1'b0, v4_val_q, 3'b000} + {3'b000, v4_val_q, 1'b0} +
                  {9'd0, tok_i.digit};

  // dotted decimal check
  always_comb begin
    v4_ok_d      = v4_ok_q;
    v4_dot_cnt_d = v4_dot_cnt_q;
    v4_len_d     = v4_len_q;
    v4_val_d     = v4_val_q;
    v4_lz_d      = v4_lz_q;
    if (tok_i.has_char) begin
      unique case (tok_i.cls)
        CC_DOT: begin
          if ((v4_len_q == '0) || (v4_val_q > V4_MAX) ||
              (v4_dot_cnt_q >= V4_DOTS)) begin
            v4_ok_d = 1'b0;
          end
          if (v4_dot_cnt_q < V4_DOT_SAT) begin
            v4_dot_cnt_d = v4_dot_cnt_q + 1'b1;
          end
          v4_len_d = '0;
          v4_val_d = '0;
          v4_lz_d  = 1'b0;
        end
        CC_DEC: begin
          if (v4_lz_q) begin
            v4_ok_d = 1'b0;
          end
          if ((v4_len_q == '0) && (tok_i.digit == '0)) begin
            v4_lz_d = 1'b1;
          end
          v4_val_d = (v4_mul > {4'd0, V4_SAT}) ? V4_SAT : v4_mul[8:0];
          if (v4_len_q < V4_LEN_SAT) begin
            v4_len_d = v4_len_q + 1'b1;
          end
        end
        default: begin
          v4_ok_d = 1'b0;
        end
      endcase
    end
  end

  // colon hex check
  always_comb begin
    v6_ok_d        = v6_ok_q;
    v6_colon_cnt_d = v6_colon_cnt_q;
    v6_len_d       = v6_len_q;
    if (tok_i.has_char) begin
      unique case (tok_i.cls)
        CC_COLON: begin
          if ((v6_len_q == '0) || (v6_len_q > V6_LEN_MAX) ||
              (v6_colon_cnt_q >= V6_COLONS)) begin
            v6_ok_d = 1'b0;
          end
          if (v6_colon_cnt_q < V6_COLON_SAT) begin
            v6_colon_cnt_d = v6_colon_cnt_q + 1'b1;
          end
          v6_len_d = '0;
        end
        CC_DEC, CC_HEX_ALPHA: begin
          if (v6_len_q < V6_LEN_SAT) begin
            v6_len_d = v6_len_q + 1'b1;
          end
        end
        default: begin
          v6_ok_d = 1'b0;
        end
      endcase
    end
  end

  // final verdict from the updated state
  assign is_v4 = v4_ok_d && (v4_dot_cnt_d == V4_DOTS) && (v4_len_d != '0) &&
                 (v4_val_d <= V4_MAX);
  assign is_v6 = v6_ok_d && (v6_colon_cnt_d == V6_COLONS) && (v6_len_d != '0) &&
                 (v6_len_d <= V6_LEN_MAX);

  // result register
  always_comb begin
    res_valid_d = res_valid_q;
    res_class_d = res_class_q;
    if (last_pop) begin
      res_valid_d = 1'b1;
      priority if (is_v4) begin
        res_class_d = AC_V4;
      end else if (is_v6) begin
        res_class_d = AC_V6;
      end else begin
        res_class_d = AC_NONE;
      end
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.address_class = res_class_q;

  // check state, back to reset after each string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_ok_q        <= 1'b1;
      v4_dot_cnt_q   <= '0;
      v4_len_q       <= '0;
      v4_val_q       <= '0;
      v4_lz_q        <= 1'b0;
      v6_ok_q        <= 1'b1;
      v6_colon_cnt_q <= '0;
      v6_len_q       <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (last_pop) begin
        v4_ok_q        <= 1'b1;
        v4_dot_cnt_q   <= '0;
        v4_len_q       <= '0;
        v4_val_q       <= '0;
        v4_lz_q        <= 1'b0;
        v6_ok_q        <= 1'b1;
        v6_colon_cnt_q <= '0;
        v6_len_q       <= '0;
      end else if (pop_o) begin
        v4_ok_q        <= v4_ok_d;
        v4_dot_cnt_q   <= v4_dot_cnt_d;
        v4_len_q       <= v4_len_d;
        v4_val_q       <= v4_val_d;
        v4_lz_q        <= v4_lz_d;
        v6_ok_q        <= v6_ok_d;
        v6_colon_cnt_q <= v6_colon_cnt_d;
        v6_len_q       <= v6_len_d;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_class_q <= res_class_d;
  end

endmodule

`default_nettype wire

[test/tb_ip_address_text_classifier.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ip_address_text_classifier
// Self-checking bench for the address text classifier. Strings go in one
// byte per transfer, and each result is compared with a behavioural scan of
// the same bytes. The run covers directed corner cases, random well-formed
// and corrupted addresses with random idling on both channels, a drain pause
// and a closing stretch with both channels at full rate.
// ----------------------------------------------------------------------------

module tb_ip_address_text_classifier;
  import iatc_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 850;
  localparam int TOTAL_ITEMS   = 1000;
  localparam int REPORT_LIMIT  = 10;

  // scan state kept alongside the block
  typedef struct {
    bit       v4_ok;
    bit [2:0] v4_dots;
    bit [2:0] v4_len;
    bit [8:0] v4_value;
    bit       v4_lead_zero;
    bit       v6_ok;
    bit [3:0] v6_colons;
    bit [2:0] v6_len;
  } addr_scan_t;

  logic clk;
  logic rst_n;

  iatc_in_if  in_if ();
  iatc_out_if res_if ();

  ip_address_text_classifier i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  addr_scan_t  scan;
  addr_class_e expected_class_q[$];
  bit [7:0]    text_q[$];
  int          items_sent;
  int          fail_count;
  int          quiet_cycles;
  bit          sender_idle_en;
  bit          sink_idle_en;
  int          sink_stall_left;

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ------------------------------------------------------------------------
  // queue helpers
  // ------------------------------------------------------------------------

  // add one byte at the tail of the string under construction
  function automatic void add_text_byte(input bit [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // add one class at the tail of the expected results
  function automatic void expect_class(input addr_class_e c);
    expected_class_q.insert(expected_class_q.size(), c);
  endfunction

  // ------------------------------------------------------------------------
  // behavioural scan
  // ------------------------------------------------------------------------

  function automatic addr_scan_t fresh_scan();
    addr_scan_t s;
    s.v4_ok        = 1'b1;
    s.v4_dots      = '0;
    s.v4_len       = '0;
    s.v4_value     = '0;
    s.v4_lead_zero = 1'b0;
    s.v6_ok        = 1'b1;
    s.v6_colons    = '0;
    s.v6_len       = '0;
    return s;
  endfunction

  // dotted decimal and colon hex checks both run on every byte
  function automatic void scan_byte(input bit [7:0] ch);
    int  next_value;
    bit  is_dec;
    bit  is_hex;
    is_dec = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_hex = is_dec || ((ch >= CH_LA) && (ch <= CH_LF)) ||
             ((ch >= CH_UA) && (ch <= CH_UF));

    if (ch == CH_DOT) begin
      if (scan.v4_len == 0 || scan.v4_value > V4_MAX) scan.v4_ok = 1'b0;
      if (scan.v4_dots < V4_DOT_SAT) scan.v4_dots++;
      if (scan.v4_dots > V4_DOTS) scan.v4_ok = 1'b0;
      scan.v4_len       = '0;
      scan.v4_value     = '0;
      scan.v4_lead_zero = 1'b0;
    end else if (is_dec) begin
      if (scan.v4_lead_zero) scan.v4_ok = 1'b0;
      if (scan.v4_len == 0 && ch == CH_ZERO) scan.v4_lead_zero = 1'b1;
      next_value = int'(scan.v4_value) * 10 + int'(ch - CH_ZERO);
      scan.v4_value = (next_value > int'(V4_SAT)) ? V4_SAT : next_value[8:0];
      if (scan.v4_len < V4_LEN_SAT) scan.v4_len++;
    end else begin
      scan.v4_ok = 1'b0;
    end

    if (ch == CH_COLON) begin
      if (scan.v6_len == 0 || scan.v6_len > V6_LEN_MAX) scan.v6_ok = 1'b0;
      if (scan.v6_colons < V6_COLON_SAT) scan.v6_colons++;
      if (scan.v6_colons > V6_COLONS) scan.v6_ok = 1'b0;
      scan.v6_len = '0;
    end else if (is_hex) begin
      if (scan.v6_len < V6_LEN_SAT) scan.v6_len++;
    end else begin
      scan.v6_ok = 1'b0;
    end
  endfunction

  // one accepted transfer: update the scan, queue a class on the last byte
  function automatic void classify_transfer(input bit [7:0] ch, input bit has,
                                            input bit lst);
    bit is_v4;
    bit is_v6;
    if (has) scan_byte(ch);
    if (lst) begin
      is_v4 = scan.v4_ok && scan.v4_dots == V4_DOTS && scan.v4_len != 0 &&
              scan.v4_value <= V4_MAX;
      is_v6 = scan.v6_ok && scan.v6_colons == V6_COLONS && scan.v6_len != 0 &&
              scan.v6_len <= V6_LEN_MAX;
      if (is_v4) expect_class(AC_V4);
      else if (is_v6) expect_class(AC_V6);
      else expect_class(AC_NONE);
      scan = fresh_scan();
    end
  endfunction

  // ------------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------------

  function automatic void note_failure(input string what, input int exp_val,
                                       input int act_val);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, exp_val, act_val);
  endfunction

  // compare each result transfer with the oldest expected class
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_class_q.size() == 0) begin
        note_failure("result with nothing pending", -1, res_if.address_class);
      end else begin
        if (res_if.address_class !== expected_class_q[0])
          note_failure("address_class", expected_class_q[0], res_if.address_class);
        void'(expected_class_q.pop_front());
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout after %0d cycles without a transfer", quiet_cycles);
          $display("FAIL ip_address_text_classifier");
          $finish;
        end
      end
    end
  end

  // result sink with random stall bursts
  always @(negedge clk) begin
    if (sink_stall_left > 0) begin
      res_if.ready = 1'b0;
      sink_stall_left--;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      res_if.ready    = 1'b0;
      sink_stall_left = $urandom_range(1, 12) - 1;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------

  // one transfer on the character channel, with an optional idle burst
  task automatic drive_item(input bit [7:0] ch, input bit has, input bit lst);
    int gap;
    @(negedge clk);
    if (sender_idle_en && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.char_code = ch;
    in_if.has_char  = has;
    in_if.last      = lst;
    do @(posedge clk); while (!in_if.ready);
    classify_transfer(ch, has, lst);
    if (has || lst) items_sent++;
  endtask

  task automatic release_channel();
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  // send text_q as one string; close it with an empty item or on the last
  // byte, and slip in dropped items at one in ignore_odds when non-zero
  task automatic send_text(input bit close_empty, input int ignore_odds);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      if (ignore_odds != 0 && $urandom_range(1, ignore_odds) == 1)
        drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      drive_item(text_q[i], 1'b1, (i == n - 1) && !close_empty);
    end
    if (close_empty || n == 0)
      drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_results_drained();
    while (expected_class_q.size() != 0) @(posedge clk);
  endtask

  function automatic void load_text(input string s);
    text_q.delete();
    for (int k = 0; k < s.len(); k++) add_text_byte(s[k]);
  endfunction

  function automatic void append_text(input string s);
    for (int k = 0; k < s.len(); k++) add_text_byte(s[k]);
  endfunction

  // bytes just outside the accepted ranges, plus arbitrary ones
  function automatic bit [7:0] odd_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return CH_ZERO - 8'd1;
      3:       return CH_UA - 8'd1;
      4:       return CH_UF + 8'd1;
      5:       return CH_LA - 8'd1;
      6:       return CH_LF + 8'd1;
      7:       return CH_NINE + 8'd2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic bit [7:0] hex_byte();
    int nib;
    nib = $urandom_range(0, 15);
    if (nib < 10) return CH_ZERO + 8'(nib);
    if ($urandom_range(0, 1) == 1) return CH_LA + 8'(nib - 10);
    return CH_UA + 8'(nib - 10);
  endfunction

  function automatic bit [7:0] any_text_byte();
    case ($urandom_range(0, 5))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return hex_byte();
      2:       return CH_DOT;
      3:       return CH_COLON;
      default: return odd_byte();
    endcase
  endfunction

  // dotted decimal string, mostly legal values
  function automatic void build_v4();
    int field_val;
    text_q.delete();
    for (int f = 0; f < 4; f++) begin
      if (f != 0) add_text_byte(CH_DOT);
      case ($urandom_range(0, 9))
        0:       field_val = 0;
        1:       field_val = 255;
        2:       field_val = 256 + $urandom_range(0, 743);
        default: field_val = $urandom_range(0, 255);
      endcase
      if ($urandom_range(0, 15) == 0) add_text_byte(CH_ZERO);
      append_text($sformatf("%0d", field_val));
    end
  endfunction

  // colon hex string, mostly 1 to 4 characters a field
  function automatic void build_v6();
    int field_len;
    text_q.delete();
    for (int f = 0; f < 8; f++) begin
      if (f != 0) add_text_byte(CH_COLON);
      field_len = $urandom_range(1, 4);
      if ($urandom_range(0, 19) == 0) field_len = $urandom_range(0, 1) * 5;
      repeat (field_len) add_text_byte(hex_byte());
    end
  endfunction

  function automatic void build_noise();
    text_q.delete();
    repeat ($urandom_range(0, 20)) add_text_byte(any_text_byte());
  endfunction

  // replace, insert or remove one byte
  function automatic void corrupt_text();
    int pos;
    if (text_q.size() == 0) begin
      add_text_byte(odd_byte());
      return;
    end
    pos = $urandom_range(0, text_q.size() - 1);
    case ($urandom_range(0, 2))
      0:       text_q[pos] = odd_byte();
      1:       text_q.insert(pos, any_text_byte());
      default: text_q.delete(pos);
    endcase
  endfunction

  task automatic send_random_string(input int ignore_odds);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) build_v4();
    else if (kind < 8) build_v6();
    else build_noise();
    if ($urandom_range(0, 3) == 0) corrupt_text();
    send_text($urandom_range(0, 9) == 0, ignore_odds);
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  task automatic test_directed();
    string dir_texts[$];
    dir_texts = '{"255.255.255.255", "0.0.0.0", "256.1.1.1", "01.2.3.4",
                  "1.2.3", "1.2.3.4.5", "1..2.3", "1.2.3.99999",
                  "FFFF:ffff:0:Ab:9:a:F:1", "12345:1:2:3:4:5:6:7",
                  "1:2:3:4:5:6:7:8:9", ":1:2:3:4:5:6:7", "1:2:3:4:5:6:7:G"};
    foreach (dir_texts[i]) begin
      load_text(dir_texts[i]);
      send_text(1'b0, 0);
    end
    // empty string
    text_q.delete();
    send_text(1'b1, 0);
    // closed by an empty item after the bytes
    load_text("10.0.0.1");
    send_text(1'b1, 0);
    // a dropped item before every byte
    load_text("192.168.0.1");
    send_text(1'b0, 1);
    // nul and all-ones bytes inside a string
    load_text("1.2.3.4");
    text_q[3] = 8'h00;
    send_text(1'b0, 0);
    load_text("a:b:c:d:e:f:1:2");
    text_q[2] = 8'hFF;
    send_text(1'b0, 0);
  endtask

  task automatic test_random_strings();
    sender_idle_en = 1'b1;
    sink_idle_en   = 1'b1;
    while (items_sent < RANDOM_ITEMS) begin
      send_random_string(24);
      // long stretches without idling now and then
      if ($urandom_range(0, 19) == 0) begin
        sender_idle_en = ~sender_idle_en;
        sink_idle_en   = $urandom_range(0, 1);
      end
    end
  endtask

  // sender holds off until every pending class has come out
  task automatic test_drain_pause();
    sender_idle_en = 1'b1;
    sink_idle_en   = 1'b1;
    repeat (4) begin
      repeat ($urandom_range(1, 3)) send_random_string(0);
      release_channel();
      wait_results_drained();
    end
  endtask

  // both channels at full rate to the end
  task automatic test_steady_stream();
    sender_idle_en = 1'b0;
    sink_idle_en   = 1'b0;
    while (items_sent < TOTAL_ITEMS) send_random_string(0);
    release_channel();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.char_code   = '0;
    in_if.has_char    = 1'b0;
    in_if.last        = 1'b0;
    res_if.ready      = 1'b0;
    sender_idle_en    = 1'b0;
    sink_idle_en      = 1'b0;
    sink_stall_left   = 0;
    items_sent        = 0;
    fail_count        = 0;
    quiet_cycles      = 0;
    scan              = fresh_scan();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_drain_pause();
    test_random_strings();
    test_steady_stream();

    // let the last classes come out, then allow for the pipeline depth
    wait_results_drained();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && expected_class_q.size() == 0) begin
      $display("PASS ip_address_text_classifier");
    end else begin
      $display("FAIL ip_address_text_classifier");
    end
    $finish;
  end

endmodule
